// ===== rtl/svt_pkg.sv =====
// ----------------------------------------------------------------------------
// svt_pkg
// Shared constants and control types for the sorted value table.
// ----------------------------------------------------------------------------
package svt_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic compare;
        logic apply;
        logic dump_load;
    } svt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dump_busy;
        logic last;
    } svt_stat_t;

endpackage

// ===== rtl/svt_ctrl.sv =====
// ----------------------------------------------------------------------------
// svt_ctrl
// Sequencer for the sorted value table: capture, compare, update, respond.
// ----------------------------------------------------------------------------
module svt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output svt_pkg::svt_cmd_t cmd,
    input  svt_pkg::svt_stat_t stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.dump_busy)
                begin
                    cmd.dump_load = 1'b1;
                end
                else
                begin
                    cmd.apply = 1'b1;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // Each accepted dump beat loads the next entry straight away.
                if (out_ready)
                begin
                    if (stat.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.dump_load = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/svt_datapath.sv =====
// ----------------------------------------------------------------------------
// svt_datapath
// Row of value cells with parallel compare flags and a one-step shift.
// ----------------------------------------------------------------------------
module svt_datapath
#(
    parameter int DEPTH = svt_pkg::DEPTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  svt_pkg::svt_cmd_t                   cmd,
    output svt_pkg::svt_stat_t                  stat,
    input  logic [svt_pkg::FUNC_W-1:0]          func,
    input  logic signed [svt_pkg::VALUE_W-1:0]  value,
    output logic [svt_pkg::STATUS_W-1:0]        status,
    output logic signed [svt_pkg::VALUE_W-1:0]  entry,
    output logic [svt_pkg::COUNT_W-1:0]         count,
    output logic                                last
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    logic signed [svt_pkg::VALUE_W-1:0] cell_reg [DEPTH];
    logic [svt_pkg::FUNC_W-1:0]         func_reg;
    logic signed [svt_pkg::VALUE_W-1:0] val_reg;
    logic [DEPTH-1:0]                   lt_reg;
    logic [DEPTH-1:0]                   eq_reg;
    logic [OCC_W-1:0]                   occ_reg;
    logic [IDX_W-1:0]                   ptr_reg;
    logic [svt_pkg::STATUS_W-1:0]       status_reg;
    logic signed [svt_pkg::VALUE_W-1:0] entry_reg;
    logic                               last_reg;

    logic        full;
    logic        found;
    logic        ins_en;
    logic        del_en;
    logic        ptr_last;
    logic [31:0] occ_wide;

    assign full     = (occ_reg == OCC_W'(DEPTH));
    assign found    = |eq_reg;
    assign ins_en   = cmd.apply && (func_reg == svt_pkg::FUNC_INSERT) && !full;
    assign del_en   = cmd.apply && (func_reg == svt_pkg::FUNC_DELETE) && found;
    assign ptr_last = ((OCC_W'(ptr_reg) + OCC_W'(1)) == occ_reg);
    assign occ_wide = 32'(occ_reg);

    assign stat.dump_busy = (func_reg == svt_pkg::FUNC_DUMP) && (occ_reg != '0);
    assign stat.last      = last_reg;

    assign status = status_reg;
    assign entry  = entry_reg;
    assign count  = occ_wide[svt_pkg::COUNT_W-1:0];
    assign last   = last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            val_reg  <= value;
        end
    end

    // Only occupied cells raise a flag. Since the row is sorted, the less-than
    // flags form a prefix, and the first cell without one is where an insert
    // lands or where the first equal entry sits.
    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                lt_reg[i] <= (OCC_W'(i) < occ_reg) && (cell_reg[i] < val_reg);
                eq_reg[i] <= (OCC_W'(i) < occ_reg) && (cell_reg[i] == val_reg);
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (ins_en && !lt_reg[g])
            begin
                if (g == 0)
                begin
                    cell_reg[g] <= val_reg;
                end
                else if (lt_reg[(g > 0) ? g - 1 : 0])
                begin
                    cell_reg[g] <= val_reg;
                end
                else
                begin
                    cell_reg[g] <= cell_reg[(g > 0) ? g - 1 : 0];
                end
            end
            else if (del_en && !lt_reg[g] && (g < DEPTH - 1))
            begin
                cell_reg[g] <= cell_reg[(g < DEPTH - 1) ? g + 1 : g];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (ins_en)
        begin
            occ_reg <= occ_reg + OCC_W'(1);
        end
        else if (del_en)
        begin
            occ_reg <= occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.capture)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.dump_load && !ptr_last)
        begin
            ptr_reg <= ptr_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dump_load)
        begin
            status_reg <= svt_pkg::ST_DONE;
            entry_reg  <= cell_reg[ptr_reg];
            last_reg   <= ptr_last;
        end
        else if (cmd.apply)
        begin
            entry_reg <= '0;
            last_reg  <= 1'b1;
            case (func_reg)
                svt_pkg::FUNC_INSERT:
                begin
                    status_reg <= full ? svt_pkg::ST_FULL : svt_pkg::ST_DONE;
                end
                svt_pkg::FUNC_DELETE:
                begin
                    status_reg <= found ? svt_pkg::ST_DONE : svt_pkg::ST_NOTFOUND;
                end
                svt_pkg::FUNC_DUMP:
                begin
                    // Reached only with an empty table.
                    status_reg <= svt_pkg::ST_EMPTY;
                end
                default:
                begin
                    status_reg <= svt_pkg::ST_DONE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sorted_value_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_value_table_core
// Bounded table of signed values kept in ascending order.
// ----------------------------------------------------------------------------
// Insert, delete and unused operations go through capture, a parallel compare
// across the cell row and a one-step shift before the result beat, and the
// next input is taken in the cycle after the result beat is accepted.
// A dump takes the same lead-in and then gives one result beat per stored
// entry, one per cycle while the consumer is ready, with last on the final
// beat; an empty table dumps as a single beat with the empty status. The
// count field always shows the occupancy after the operation.
module sorted_value_table_core
#(
    parameter int DEPTH = svt_pkg::DEPTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [svt_pkg::FUNC_W-1:0]          func,
    input  logic signed [svt_pkg::VALUE_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [svt_pkg::STATUS_W-1:0]        status,
    output logic signed [svt_pkg::VALUE_W-1:0]  entry,
    output logic [svt_pkg::COUNT_W-1:0]         count,
    output logic                                last
);

    svt_pkg::svt_cmd_t  cmd;
    svt_pkg::svt_stat_t stat;

    svt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    svt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .func   (func),
        .value  (value),
        .status (status),
        .entry  (entry),
        .count  (count),
        .last   (last)
    );

endmodule
